FILE: src/trial_division_prime_test_macros.svh
// ----------------------------------------------------------------------------
// Trial division prime test: assertion macros
// Shared concurrent assertion wrappers, clocked on clk; TDP_ASSERT is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Checked only outside reset
`define TDP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define TDP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test: package
// Shared constants and the status bundle of the serial remainder unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

    // Default candidate width
    localparam int VALUE_BITS_DEFAULT = 10;

    // Smallest divisor tried
    localparam int FIRST_DIVISOR = 2;

    // Status from the remainder unit to the controller
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder is final
        logic zero;   // remainder is zero (valid with done)
    } rem_status_t;

endpackage

FILE: src/tdp_rem_serial.sv
// ----------------------------------------------------------------------------
// Trial division prime test: serial remainder unit
// Restoring division, one dividend bit per cycle, MSB first. Reports only
// whether the remainder is zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_rem_serial #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   dividend,
    input  logic [VALUE_BITS-1:0]   divisor,
    output tdp_pkg::rem_status_t    status
);
    import tdp_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_LOAD = CNT_BITS'(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [VALUE_BITS-1:0] shift_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = diff[VALUE_BITS-1:0];
        end
        else
        begin
            rem_next = trial[VALUE_BITS-1:0];
        end
    end

    // Control: bit counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LOAD;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_LAST;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: dividend shifter and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[VALUE_BITS-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

FILE: src/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test: top level
// Tests one unsigned candidate at a time for primality by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries candidate; a transaction takes
//   place when in_valid is high and in_stall is low. in_stall is high while
//   a candidate is being tested.
//   Output channel out_valid / out_stall carries is_prime, one result per
//   candidate, held in an output register. A new candidate is taken while
//   an earlier result still waits there.
//   Divisors d = 2, 3, ... are tried while d*d <= candidate; the search ends
//   at the first divisor leaving no remainder. Each divisor is tried in turn
//   in the bit-serial remainder unit. Candidates 0 and 1 report not prime
//   without any division. If the receiver stalls, the result waits in the
//   output register; a later finished result waits in the controller until
//   that slot frees.
//   rst_n is asynchronous and active low; it empties both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trial_division_prime_test #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] candidate,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  is_prime
);
    import tdp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TEST   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [VALUE_BITS-1:0] D_INIT  = VALUE_BITS'(FIRST_DIVISOR);
    localparam logic [VALUE_BITS:0]   SQ_INIT = (VALUE_BITS+1)'(FIRST_DIVISOR * FIRST_DIVISOR);

    state_t                state_reg;
    state_t                state_next;
    logic [VALUE_BITS-1:0] n_reg;
    logic [VALUE_BITS-1:0] d_reg;
    logic [VALUE_BITS:0]   sq_reg;
    logic                  result_reg;
    logic                  out_valid_reg;
    logic                  is_prime_reg;
    logic                  rem_start;
    logic                  in_take;
    logic                  out_free;
    logic                  below_two;
    logic                  sq_over;
    rem_status_t           rem_status;

    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign below_two = (n_reg[VALUE_BITS-1:1] == '0);
    assign sq_over   = (sq_reg > {1'b0, n_reg});
    assign rem_start = (state_reg == ST_TEST) && !below_two && !sq_over;

    // Serial remainder of n by the current divisor
    tdp_rem_serial #(
        .VALUE_BITS (VALUE_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (below_two || sq_over)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    state_next = rem_status.zero ? ST_FINISH : ST_TEST;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Candidate, divisor, divisor square and result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            n_reg  <= candidate;
            d_reg  <= D_INIT;
            sq_reg <= SQ_INIT;
        end
        if (state_reg == ST_TEST)
        begin
            result_reg <= !below_two;
        end
        if ((state_reg == ST_DIVIDE) && rem_status.done)
        begin
            if (rem_status.zero)
            begin
                result_reg <= 1'b0;
            end
            // (d+1)^2 = d^2 + 2d + 1
            sq_reg <= sq_reg + {d_reg, 1'b1};
            d_reg  <= d_reg + VALUE_BITS'(1);
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            is_prime_reg <= result_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

FILE: src/tdp_checker.sv
// ----------------------------------------------------------------------------
// Trial division prime test: port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trial_division_prime_test_macros.svh"

module tdp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall
,   input logic is_prime
);

    // A stalled result holds
    `TDP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(is_prime), "stalled result changed")

    // An accepted candidate keeps the block busy in the next cycle
    `TDP_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "input taken twice in a row")

    // A new result only follows a cycle of work
    `TDP_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result without work")

    // Nothing leaves during reset
    `TDP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid && !in_stall, "channel active in reset")

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
